[rtl/mbrc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbrc_pkg
// Types and constants shared by the Modbus RTU request checker.
// ----------------------------------------------------------------------------
package mbrc_pkg;

	typedef logic [7:0]  byte_t;
	typedef logic [15:0] crc_t;
	typedef logic [1:0]  status_t;
	typedef logic [2:0]  count_t;

	localparam crc_t   CRC_INIT       = 16'hFFFF;
	localparam crc_t   CRC_POLY       = 16'hA001;
	localparam byte_t  EXC_BASE       = 8'h80;
	localparam byte_t  SLAVE_ADDR_RST = 8'h01;

	// Supported function codes
	localparam byte_t  FN_READ_HOLDING  = 8'd3;
	localparam byte_t  FN_WRITE_SINGLE  = 8'd6;
	localparam byte_t  FN_WRITE_MULTI   = 8'd16;

	// Bytes of a frame counted before saturation; a frame needs this many
	localparam count_t MIN_FRAME = 3'd4;

	// Status codes
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_CRC_ERR   = 2'd1;
	localparam status_t ST_ADDR_MISS = 2'd2;
	localparam status_t ST_SHORT     = 2'd3;

	// Exception code: illegal function
	localparam logic EXC_ILLEGAL_FN = 1'b1;

	typedef struct packed {
		status_t status;
		byte_t   function_code;
		logic    supported;
		byte_t   exception_function;
		logic    exception_code;
	} result_t;

endpackage
`default_nettype wire

[rtl/mbrc_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbrc_if
// Valid/ready channels of the request checker: frame bytes in, verdicts out,
// and the slave address write channel.
// ----------------------------------------------------------------------------
interface mbrc_req_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       last_byte;

	modport source (output valid, output frame_byte, output last_byte, input ready);
	modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface mbrc_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [7:0] function_code;
	logic       supported;
	logic [7:0] exception_function;
	logic       exception_code;

	modport source (output valid, output status, output function_code,
		output supported, output exception_function, output exception_code,
		input ready);
	modport sink   (input valid, input status, input function_code,
		input supported, input exception_function, input exception_code,
		output ready);
endinterface

interface mbrc_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] slave_address;

	modport source (output valid, output slave_address, input ready);
	modport sink   (input valid, input slave_address, output ready);
endinterface
`default_nettype wire

[rtl/mbrc_crc_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbrc_crc_step
// One byte of CRC-16/Modbus, eight reflected shift steps unrolled.
// ----------------------------------------------------------------------------
module mbrc_crc_step
	import mbrc_pkg::*;
(
	input  wire crc_t  crc_in,
	input  wire byte_t data_in,
	output crc_t       crc_out
);

	always_comb begin
		crc_t c;
		c = crc_in ^ {8'h00, data_in};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_out = c;
	end

endmodule
`default_nettype wire

[rtl/mbrc_frame.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbrc_frame
// Per-frame state (CRC, delay line, byte count, header bytes) and the verdict
// for the byte being taken.
// ----------------------------------------------------------------------------
module mbrc_frame
	import mbrc_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        step,
	input  wire byte_t data_in,
	input  wire        last_in,
	input  wire byte_t slave_address,
	output result_t    result
);

	crc_t   crc_q, crc_fed, crc_nx;
	byte_t  older_q, newer_q, addr_q, func_q;
	byte_t  addr_nx, func_nx;
	count_t seen_q, seen_nx;
	logic   sup;
	logic   short_frame;
	crc_t   crc_rx;

	mbrc_crc_step u_crc (
		.crc_in  (crc_q),
		.data_in (older_q),
		.crc_out (crc_fed)
	);

	always_comb begin
		crc_nx  = (seen_q >= 3'd2) ? crc_fed : crc_q;
		addr_nx = (seen_q == 3'd0) ? data_in : addr_q;
		func_nx = (seen_q == 3'd1) ? data_in : func_q;
		seen_nx = (seen_q < MIN_FRAME) ? seen_q + 3'd1 : seen_q;
		// fewer than four bytes including this one
		short_frame = seen_q < (MIN_FRAME - 3'd1);
		crc_rx = {data_in, newer_q};
		sup = (func_nx == FN_READ_HOLDING) || (func_nx == FN_WRITE_SINGLE) ||
			(func_nx == FN_WRITE_MULTI);

		if (short_frame) begin
			result.status = ST_SHORT;
		end else if (crc_rx != crc_nx) begin
			result.status = ST_CRC_ERR;
		end else if (addr_nx != slave_address) begin
			result.status = ST_ADDR_MISS;
		end else begin
			result.status = ST_OK;
		end
		result.function_code      = func_nx;
		result.supported          = sup;
		result.exception_function = sup ? 8'h00 : EXC_BASE + func_nx;
		result.exception_code     = (result.status == ST_OK && !sup) ? EXC_ILLEGAL_FN : 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= CRC_INIT;
			older_q <= '0;
			newer_q <= '0;
			seen_q  <= '0;
			addr_q  <= '0;
			func_q  <= '0;
		end else if (step) begin
			if (last_in) begin
				// reload for the next frame
				crc_q   <= CRC_INIT;
				older_q <= '0;
				newer_q <= '0;
				seen_q  <= '0;
				addr_q  <= '0;
				func_q  <= '0;
			end else begin
				crc_q   <= crc_nx;
				older_q <= newer_q;
				newer_q <= data_in;
				seen_q  <= seen_nx;
				addr_q  <= addr_nx;
				func_q  <= func_nx;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/modbus_rtu_request_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_rtu_request_checker
// Checks Modbus RTU request frames fed one byte per item: CRC-16/Modbus over
// all but the last two bytes, slave address, and function code support.
// The final byte goes through the input register, then the verdict register.
// Throughput: one byte per cycle; a verdict stalls input only while the output
// register is full and not taken.
// Reset: frame state clears, slave address returns to 1, channels go idle.
// ----------------------------------------------------------------------------
module modbus_rtu_request_checker
	import mbrc_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	mbrc_req_if.sink    req,
	mbrc_rsp_if.source  rsp,
	mbrc_cfg_if.sink    cfg
);

	// Input register stage
	logic    valid_s1;
	byte_t   byte_s1;
	logic    last_s1;

	// Output register
	logic    rsp_valid_q;
	result_t result_q;

	byte_t   slave_addr_q;
	result_t result;
	logic    out_free;
	logic    advance;

	// Output register can take a new verdict this cycle
	assign out_free = !rsp_valid_q || rsp.ready;
	// Advance the staged byte into the frame state; a final byte also needs room
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign req.ready = !valid_s1 || advance;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= SLAVE_ADDR_RST;
		end else if (cfg.valid) begin
			slave_addr_q <= cfg.slave_address;
		end
	end

	// Hold the incoming item until the frame logic takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			byte_s1 <= req.frame_byte;
			last_s1 <= req.last_byte;
		end
	end

	mbrc_frame u_frame (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.data_in       (byte_s1),
		.last_in       (last_s1),
		.slave_address (slave_addr_q),
		.result        (result)
	);

	// Load a verdict on the final byte; drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			result_q <= result;
		end
	end

	assign rsp.valid              = rsp_valid_q;
	assign rsp.status             = result_q.status;
	assign rsp.function_code      = result_q.function_code;
	assign rsp.supported          = result_q.supported;
	assign rsp.exception_function = result_q.exception_function;
	assign rsp.exception_code     = result_q.exception_code;

endmodule
`default_nettype wire

[bench/modbus_rtu_request_checker_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_request_checker_tb
// Self-checking bench for the Modbus RTU request checker. A short table of
// hand-built frames comes first. Then random frames run in three idling phases
// and under several slave addresses. Each item sent is fed to a bench-side copy
// of the frame logic. Every verdict that leaves the block is checked field by
// field against the oldest expected verdict.
// ----------------------------------------------------------------------------
module modbus_rtu_request_checker_tb;
	import mbrc_pkg::*;

	// How the table fills in the CRC bytes of a frame
	typedef enum logic [1:0] {
		FILL_NONE,
		FILL_CRC_LO,
		FILL_CRC_HI,
		FILL_CRC_LO_BAD
	} crc_fill_t;

	typedef struct {
		byte_t     data;
		logic      last;
		crc_fill_t fill;
		bit        typed;    // verdict column holds the expected result
		result_t   verdict;
	} dir_row_t;

	localparam int DIR_ROWS     = 26;
	localparam int RANDOM_ITEMS = 1600;
	localparam int BLOCKS       = 6;
	localparam int SETTLE       = 8;    // idle clocks after the last verdict is taken

	// Hand-built frames. The first one is the well-known read of one holding
	// register at address 0 from slave 1; its CRC bytes are 84 0A.
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{8'h01, 1'b0, FILL_NONE, 1'b0, '0},
		'{8'h03, 1'b0, FILL_NONE, 1'b0, '0},
		'{8'h00, 1'b0, FILL_NONE, 1'b0, '0},
		'{8'h00, 1'b0, FILL_NONE, 1'b0, '0},
		'{8'h00, 1'b0, FILL_NONE, 1'b0, '0},
		'{8'h01, 1'b0, FILL_NONE, 1'b0, '0},
		'{8'h84, 1'b0, FILL_NONE, 1'b0, '0},
		'{8'h0A, 1'b1, FILL_NONE, 1'b1, '{ST_OK, FN_READ_HOLDING, 1'b1, 8'h00, 1'b0}},
		// one-byte frame: no function byte seen, so it reads as zero
		'{8'hFF, 1'b1, FILL_NONE, 1'b1, '{ST_SHORT, 8'h00, 1'b0, 8'h80, 1'b0}},
		// two-byte frame with a supported function
		'{8'h01, 1'b0, FILL_NONE, 1'b0, '0},
		'{8'h10, 1'b1, FILL_NONE, 1'b1, '{ST_SHORT, FN_WRITE_MULTI, 1'b1, 8'h00, 1'b0}},
		// three-byte frame; exception function wraps past 0xFF
		'{8'h00, 1'b0, FILL_NONE, 1'b0, '0},
		'{8'hFF, 1'b0, FILL_NONE, 1'b0, '0},
		'{8'hAA, 1'b1, FILL_NONE, 1'b1, '{ST_SHORT, 8'hFF, 1'b0, 8'h7F, 1'b0}},
		// minimal good frame with an illegal function
		'{8'h01, 1'b0, FILL_NONE,   1'b0, '0},
		'{8'h7F, 1'b0, FILL_NONE,   1'b0, '0},
		'{8'h00, 1'b0, FILL_CRC_LO, 1'b0, '0},
		'{8'h00, 1'b1, FILL_CRC_HI, 1'b1, '{ST_OK, 8'h7F, 1'b0, 8'hFF, EXC_ILLEGAL_FN}},
		// good CRC, wrong address
		'{8'hFE, 1'b0, FILL_NONE,   1'b0, '0},
		'{8'h06, 1'b0, FILL_NONE,   1'b0, '0},
		'{8'h00, 1'b0, FILL_CRC_LO, 1'b0, '0},
		'{8'h00, 1'b1, FILL_CRC_HI, 1'b1,
			'{ST_ADDR_MISS, FN_WRITE_SINGLE, 1'b1, 8'h00, 1'b0}},
		// bad CRC; exception function of 0x80 wraps to zero
		'{8'h01, 1'b0, FILL_NONE,       1'b0, '0},
		'{8'h80, 1'b0, FILL_NONE,       1'b0, '0},
		'{8'h00, 1'b0, FILL_CRC_LO_BAD, 1'b0, '0},
		'{8'h00, 1'b1, FILL_CRC_HI,     1'b1, '{ST_CRC_ERR, 8'h80, 1'b0, 8'h00, 1'b0}}
	};

	logic clk = 1'b0;
	logic arst_n;

	mbrc_req_if req_ch ();
	mbrc_rsp_if rsp_ch ();
	mbrc_cfg_if cfg_ch ();

	modbus_rtu_request_checker u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Bench copy of the frame state and the slave address register
	byte_t  slave_addr_copy;
	crc_t   crc_run;
	byte_t  dly_old;
	byte_t  dly_new;
	count_t seen_cnt;
	byte_t  addr_seen;
	byte_t  fn_seen;

	result_t verdict_q [$];

	int src_idle_pct;
	int snk_idle_pct;
	int items_sent;
	int err_count;
	int frames_checked;
	int n_ok, n_crc, n_addr, n_short, n_illegal;

	// One byte through the reflected CRC-16/Modbus polynomial
	function automatic crc_t crc16_update(input crc_t crc, input byte_t b);
		crc_t c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	function automatic void clear_frame();
		crc_run   = CRC_INIT;
		dly_old   = '0;
		dly_new   = '0;
		seen_cnt  = '0;
		addr_seen = '0;
		fn_seen   = '0;
	endfunction

	// Advance the frame state by one byte; return 1 with the verdict on the
	// marked byte.
	function automatic bit predict_verdict(input byte_t b, input logic last,
		output result_t v);
		int      total;
		logic    sup;
		crc_t    crc_rx;
		status_t st;
		v = '0;
		if (seen_cnt >= 2)
			crc_run = crc16_update(crc_run, dly_old);
		if (seen_cnt == 0)
			addr_seen = b;
		else if (seen_cnt == 1)
			fn_seen = b;
		dly_old = dly_new;
		dly_new = b;
		total = int'(seen_cnt) + 1;
		if (seen_cnt < MIN_FRAME)
			seen_cnt = seen_cnt + 1'b1;
		if (!last)
			return 1'b0;

		sup = (fn_seen == FN_READ_HOLDING) || (fn_seen == FN_WRITE_SINGLE) ||
			(fn_seen == FN_WRITE_MULTI);
		crc_rx = {dly_new, dly_old};
		if (total < int'(MIN_FRAME))
			st = ST_SHORT;
		else if (crc_rx != crc_run)
			st = ST_CRC_ERR;
		else if (addr_seen != slave_addr_copy)
			st = ST_ADDR_MISS;
		else
			st = ST_OK;

		v.status             = st;
		v.function_code      = fn_seen;
		v.supported          = sup;
		v.exception_function = sup ? 8'h00 : byte_t'(EXC_BASE + fn_seen);
		v.exception_code     = (st == ST_OK && !sup) ? EXC_ILLEGAL_FN : 1'b0;
		clear_frame();
		return 1'b1;
	endfunction

	// Offer one byte, hold it until taken, then queue its verdict if any.
	// A typed verdict from the table replaces the predicted one.
	task automatic send_item(input byte_t b, input logic last, input bit typed,
		input result_t fixed);
		result_t v;
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.frame_byte <= b;
		req_ch.last_byte  <= last;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		items_sent++;
		if (predict_verdict(b, last, v))
			verdict_q.push_back(typed ? fixed : v);
	endtask

	// Stop sending and let every pending verdict drain
	task automatic drain_verdicts();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_slave_address(input byte_t a);
		cfg_ch.valid         <= 1'b1;
		cfg_ch.slave_address <= a;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		slave_addr_copy = a;
		cfg_ch.valid <= 1'b0;
	endtask

	// One random frame: mostly well formed with random content, some short,
	// some corrupted, some plain noise.
	task automatic send_frame();
		byte_t fbytes [$];
		int    kind;
		int    len;
		crc_t  c;
		int    pick;
		kind = $urandom_range(99);
		if (kind < 8) begin
			// noise
			len = $urandom_range(1, 10);
			repeat (len) fbytes.push_back(byte_t'($urandom_range(255)));
		end else begin
			fbytes.push_back(($urandom_range(99) < 70) ? slave_addr_copy :
				byte_t'($urandom_range(255)));
			pick = $urandom_range(5);
			case (pick)
				0:       fbytes.push_back(FN_READ_HOLDING);
				1:       fbytes.push_back(FN_WRITE_SINGLE);
				2:       fbytes.push_back(FN_WRITE_MULTI);
				default: fbytes.push_back(byte_t'($urandom_range(255)));
			endcase
			if (kind < 16) begin
				// short frame: keep one to three bytes
				len = $urandom_range(1, 3);
				while (fbytes.size() > len) void'(fbytes.pop_back());
				if (len == 3) fbytes.push_back(byte_t'($urandom_range(255)));
			end else begin
				// mostly small bodies, now and then a long one
				len = ($urandom_range(9) == 0) ? $urandom_range(8, 40) :
					$urandom_range(0, 6);
				repeat (len) fbytes.push_back(byte_t'($urandom_range(255)));
				c = CRC_INIT;
				foreach (fbytes[i]) c = crc16_update(c, fbytes[i]);
				fbytes.push_back(c[7:0]);
				fbytes.push_back(c[15:8]);
				// flip one bit somewhere in a few frames
				if ($urandom_range(99) < 12) begin
					pick = $urandom_range(fbytes.size() - 1);
					fbytes[pick][$urandom_range(7)] ^= 1'b1;
				end
			end
		end
		foreach (fbytes[i])
			send_item(fbytes[i], i == fbytes.size() - 1, 1'b0, '0);
	endtask

	// Receiver: drop ready at random per the current idle rate
	always @(posedge clk)
		rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);

	// Check every verdict taken against the oldest one expected
	always @(posedge clk) begin
		result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (verdict_q.size() == 0) begin
				$error("verdict with none expected: status %0d function_code %0h",
					rsp_ch.status, rsp_ch.function_code);
				err_count++;
			end else begin
				want = verdict_q.pop_front();
				frames_checked++;
				case (want.status)
					ST_OK:        n_ok++;
					ST_CRC_ERR:   n_crc++;
					ST_ADDR_MISS: n_addr++;
					default:      n_short++;
				endcase
				if (want.exception_code == EXC_ILLEGAL_FN)
					n_illegal++;
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
					err_count++;
				end
				if (rsp_ch.function_code !== want.function_code) begin
					$error("function_code: expected %0h, got %0h",
						want.function_code, rsp_ch.function_code);
					err_count++;
				end
				if (rsp_ch.supported !== want.supported) begin
					$error("supported: expected %0d, got %0d",
						want.supported, rsp_ch.supported);
					err_count++;
				end
				if (rsp_ch.exception_function !== want.exception_function) begin
					$error("exception_function: expected %0h, got %0h",
						want.exception_function, rsp_ch.exception_function);
					err_count++;
				end
				if (rsp_ch.exception_code !== want.exception_code) begin
					$error("exception_code: expected %0d, got %0d",
						want.exception_code, rsp_ch.exception_code);
					err_count++;
				end
			end
		end
	end

	// Main sequence
	initial begin
		byte_t b;
		crc_t  frame_crc;
		int    goal;
		byte_t addr_plan [BLOCKS];

		arst_n               <= 1'b0;
		req_ch.valid         <= 1'b0;
		req_ch.frame_byte    <= '0;
		req_ch.last_byte     <= 1'b0;
		cfg_ch.valid         <= 1'b0;
		cfg_ch.slave_address <= '0;
		src_idle_pct    = 0;
		snk_idle_pct    = 0;
		items_sent      = 0;
		err_count       = 0;
		frames_checked  = 0;
		n_ok = 0; n_crc = 0; n_addr = 0; n_short = 0; n_illegal = 0;
		slave_addr_copy = SLAVE_ADDR_RST;
		clear_frame();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames at the reset address, with light idling on both sides
		src_idle_pct <= 20;
		snk_idle_pct <= 20;
		frame_crc = CRC_INIT;
		foreach (dir_rows[i]) begin
			case (dir_rows[i].fill)
				FILL_CRC_LO:     b = frame_crc[7:0];
				FILL_CRC_HI:     b = frame_crc[15:8];
				FILL_CRC_LO_BAD: b = ~frame_crc[7:0];
				default: begin
					b = dir_rows[i].data;
					frame_crc = crc16_update(frame_crc, b);
				end
			endcase
			if (dir_rows[i].last)
				frame_crc = CRC_INIT;
			send_item(b, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].verdict);
		end

		// Random frames: two address settings per idling phase, both extremes
		addr_plan[0] = 8'hFF;
		addr_plan[1] = 8'h00;
		addr_plan[2] = byte_t'($urandom_range(255));
		addr_plan[3] = SLAVE_ADDR_RST;
		addr_plan[4] = byte_t'($urandom_range(255));
		addr_plan[5] = 8'hA5;
		for (int blk = 0; blk < BLOCKS; blk++) begin
			// pause until every verdict is out, then reconfigure while idle
			drain_verdicts();
			case (blk / 2)
				0: begin
					src_idle_pct <= 37;
					snk_idle_pct <= 85;
				end
				1: begin
					src_idle_pct <= 85;
					snk_idle_pct <= 37;
				end
				default: begin
					src_idle_pct <= 0;
					snk_idle_pct <= 0;
				end
			endcase
			write_slave_address(addr_plan[blk]);
			goal = DIR_ROWS + (blk + 1) * (RANDOM_ITEMS / BLOCKS);
			while (items_sent < goal)
				send_frame();
		end

		drain_verdicts();
		$display("Checked %0d verdicts over %0d bytes: %0d ok, %0d bad CRC,",
			frames_checked, items_sent, n_ok, n_crc);
		$display("%0d wrong address, %0d short, %0d illegal function.",
			n_addr, n_short, n_illegal);
		if (err_count == 0 && verdict_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog: far beyond the slowest good run
	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

[modbus_rtu_request_checker.f]
rtl/mbrc_pkg.sv
rtl/mbrc_if.sv
rtl/mbrc_crc_step.sv
rtl/mbrc_frame.sv
rtl/modbus_rtu_request_checker.sv
bench/modbus_rtu_request_checker_tb.sv
